// ===== hw/rtl/fhlc_pkg.sv =====
// ----------------------------------------------------------------------------
// fhlc_pkg
// Shared types and constants of the frame header, length and checksum checker.
// ----------------------------------------------------------------------------
package fhlc_pkg;

	// Frame limits
	localparam logic [8:0] COUNT_MAX     = 9'd511;
	localparam logic [8:0] MIN_FRAME     = 9'd5;
	localparam logic [8:0] LENGTH_OFFSET = 9'd3;

	// Header register reset values ('T' and 'G')
	localparam logic [7:0] HEADER_FIRST_RST  = 8'd84;
	localparam logic [7:0] HEADER_SECOND_RST = 8'd71;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_HEADER_FIRST  = 1'b0,
		REG_HEADER_SECOND = 1'b1
	} reg_index_t;

	// Frame verdict codes
	typedef enum logic [2:0] {
		ST_VALID        = 3'd0,
		ST_TOO_SHORT    = 3'd1,
		ST_BAD_HEADER   = 3'd2,
		ST_LEN_MISMATCH = 3'd3,
		ST_SUM_MISMATCH = 3'd4
	} status_t;

	// One received byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// One frame verdict
	typedef struct packed {
		status_t    status;
		logic [7:0] sender_high;
		logic [7:0] sender_low;
		logic [7:0] declared_length;
	} out_item_t;

	// Handshake between the frame checker stage and the result register
	typedef struct packed {
		logic load;     // result register takes a verdict this cycle
		logic can_load; // result register is empty or being drained
	} res_ctrl_t;

endpackage

// ===== hw/rtl/fhlc_frame_check.sv =====
// ----------------------------------------------------------------------------
// fhlc_frame_check
// Per-frame state (byte count, running sum, header match, length and sender
// bytes) and the combinational verdict for a final byte.
// ----------------------------------------------------------------------------
module fhlc_frame_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,          // item in the input stage is consumed
	input  fhlc_pkg::in_item_t item,
	input  logic [7:0]         header_first,
	input  logic [7:0]         header_second,
	output fhlc_pkg::out_item_t result
);
	import fhlc_pkg::*;

	logic [8:0] byte_count_q;
	logic [7:0] running_sum_q;
	logic       header_match_q;
	logic [7:0] length_byte_q;
	logic [7:0] sender_first_q;
	logic [7:0] sender_second_q;

	logic [8:0] frame_len;
	status_t    status;

	// Frame length including the final byte, saturated
	assign frame_len = (byte_count_q < COUNT_MAX) ? (byte_count_q + 9'd1) : COUNT_MAX;

	// Verdict, first failing check wins
	always_comb begin
		priority if (frame_len < MIN_FRAME) begin
			status = ST_TOO_SHORT;
		end else if (!header_match_q) begin
			status = ST_BAD_HEADER;
		end else if ({1'b0, length_byte_q} != (frame_len - LENGTH_OFFSET)) begin
			status = ST_LEN_MISMATCH;
		end else if (running_sum_q != item.data_byte) begin
			status = ST_SUM_MISMATCH;
		end else begin
			status = ST_VALID;
		end
	end

	assign result.status          = status;
	assign result.sender_high     = sender_first_q;
	assign result.sender_low      = sender_second_q;
	assign result.declared_length = length_byte_q;

	// Frame state: capture fields by position, clear after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			running_sum_q   <= '0;
			header_match_q  <= 1'b1;
			length_byte_q   <= '0;
			sender_first_q  <= '0;
			sender_second_q <= '0;
		end else if (step) begin
			if (item.last_byte) begin
				byte_count_q    <= '0;
				running_sum_q   <= '0;
				header_match_q  <= 1'b1;
				length_byte_q   <= '0;
				sender_first_q  <= '0;
				sender_second_q <= '0;
			end else begin
				unique case (byte_count_q)
					9'd0: begin
						if (item.data_byte != header_first) header_match_q <= 1'b0;
					end
					9'd1: begin
						if (item.data_byte != header_second) header_match_q <= 1'b0;
					end
					9'd2: length_byte_q   <= item.data_byte;
					9'd3: sender_first_q  <= item.data_byte;
					9'd4: sender_second_q <= item.data_byte;
					default: ;
				endcase
				running_sum_q <= running_sum_q + item.data_byte;
				if (byte_count_q < COUNT_MAX) byte_count_q <= byte_count_q + 9'd1;
			end
		end
	end

	// Frame state is back at its start values after a final byte
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.last_byte) |=> (byte_count_q == 9'd0 && running_sum_q == 8'd0
			&& header_match_q))
		else $error("frame state not cleared after final byte");

	// Running sum follows every non-final byte
	a_sum_update: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !item.last_byte)
		|=> running_sum_q == 8'($past(running_sum_q) + $past(item.data_byte)))
		else $error("running sum not updated");

	// Any frame under five bytes reports too short
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.last_byte && byte_count_q < 9'd4) |-> status == ST_TOO_SHORT)
		else $error("short frame not flagged");

endmodule

// ===== hw/rtl/fhlc_out_reg.sv =====
// ----------------------------------------------------------------------------
// fhlc_out_reg
// Result register: holds one verdict until the output transaction completes.
// ----------------------------------------------------------------------------
module fhlc_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  fhlc_pkg::out_item_t result,
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_ready,
	output fhlc_pkg::out_item_t out_data
);
	import fhlc_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (load) data_q <= result;
	end

	// A verdict never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!valid_q || out_ready))
		else $error("result register overwritten");

	// Loading always presents a result next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded result not shown");

	// A pending, unaccepted result stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> valid_q)
		else $error("pending result dropped");

endmodule

// ===== hw/rtl/frame_header_length_checksum_check_unit.sv =====
// ----------------------------------------------------------------------------
// frame_header_length_checksum_check_unit
// Received-frame checker: header, declared length and 8-bit checksum verdict.
// ----------------------------------------------------------------------------
// Accepts one frame byte per cycle unless a final byte is held in the input
// register. A byte lands in the input register and is folded into the frame
// state (count, running sum, header match, length and sender bytes) when it
// leaves that register. A final byte then also writes its verdict into the
// result register, which raises out_valid. Non-final bytes never wait for the
// output side; a final byte waits in the input register only while the
// previous verdict is still held by the result register. Header registers
// are written through cfg_we / cfg_index / cfg_wdata and should be changed
// between frames.
// ----------------------------------------------------------------------------
module frame_header_length_checksum_check_unit (
	input  logic                clk,
	input  logic                arst_n,
	// byte input
	input  logic                in_valid,
	output logic                in_ready,
	input  fhlc_pkg::in_item_t  in_data,
	// verdict output
	output logic                out_valid,
	input  logic                out_ready,
	output fhlc_pkg::out_item_t out_data,
	// configuration write
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [7:0]          cfg_wdata
);
	import fhlc_pkg::*;

	logic        valid_s1;
	in_item_t    item_s1;
	logic        step;
	res_ctrl_t   res_ctrl;
	out_item_t   result;
	logic [7:0]  header_first_q;
	logic [7:0]  header_second_q;

	// Header registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= HEADER_FIRST_RST;
			header_second_q <= HEADER_SECOND_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_HEADER_FIRST:  header_first_q  <= cfg_wdata;
				REG_HEADER_SECOND: header_second_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input stage advance: final bytes need room in the result register
	assign step          = valid_s1 && (!item_s1.last_byte || res_ctrl.can_load);
	assign res_ctrl.load = step && item_s1.last_byte;
	assign in_ready      = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_data;
	end

	fhlc_frame_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.item          (item_s1),
		.header_first  (header_first_q),
		.header_second (header_second_q),
		.result        (result)
	);

	fhlc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_ctrl.load),
		.result    (result),
		.can_load  (res_ctrl.can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Input only stalls behind a held final byte
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && item_s1.last_byte && out_valid && !out_ready))
		else $error("input stalled without cause");

	// Non-final bytes always leave the input stage without waiting
	a_nonlast_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !item_s1.last_byte) |-> step)
		else $error("non-final byte held");

	// A consumed final byte yields a verdict next cycle
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.last_byte) |=> out_valid)
		else $error("final byte gave no verdict");

endmodule

// ===== dv/fhlc_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// fhlc_verdict_checker
// Watches the byte, verdict and header-write ports of the frame checker.
// It folds every accepted byte into its own copy of the frame state, keeps
// its own header registers, queues one expected verdict per final byte and
// compares each accepted verdict, field by field, with the oldest one queued.
// ----------------------------------------------------------------------------
module fhlc_verdict_checker
	import fhlc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  in_item_t   in_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  out_item_t  out_data,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	output int         mismatch_count,
	output int         verdicts_pending,
	output int         verdicts_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// Header registers as last written
	logic [7:0] hdr_first_now  = HEADER_FIRST_RST;
	logic [7:0] hdr_second_now = HEADER_SECOND_RST;

	// Frame state: bytes before the current one and what they carried
	logic [8:0] frame_count    = '0;
	logic [7:0] frame_sum      = '0;
	logic       header_ok      = 1'b1;
	logic [7:0] length_seen    = '0;
	logic [7:0] sender_hi_seen = '0;
	logic [7:0] sender_lo_seen = '0;

	out_item_t  expected_verdicts[$];
	int         fails   = 0;
	int         checked = 0;

	task automatic clear_frame_state();
		frame_count    = '0;
		frame_sum      = '0;
		header_ok      = 1'b1;
		length_seen    = '0;
		sender_hi_seen = '0;
		sender_lo_seen = '0;
	endtask

	// Fold one byte into the frame; a final byte yields the frame's verdict
	task automatic fold_frame_byte(input in_item_t item);
		logic [8:0] frame_len;
		out_item_t  verdict;
		if (!item.last_byte) begin
			case (frame_count)
				9'd0: if (item.data_byte != hdr_first_now) header_ok = 1'b0;
				9'd1: if (item.data_byte != hdr_second_now) header_ok = 1'b0;
				9'd2: length_seen = item.data_byte;
				9'd3: sender_hi_seen = item.data_byte;
				9'd4: sender_lo_seen = item.data_byte;
				default: ;
			endcase
			frame_sum = frame_sum + item.data_byte;
			if (frame_count < COUNT_MAX) frame_count = frame_count + 9'd1;
		end else begin
			// length includes the final byte, saturated
			frame_len = (frame_count < COUNT_MAX) ? frame_count + 9'd1 : COUNT_MAX;
			if (frame_len < MIN_FRAME) begin
				verdict.status = ST_TOO_SHORT;
			end else if (!header_ok) begin
				verdict.status = ST_BAD_HEADER;
			end else if ({1'b0, length_seen} != frame_len - LENGTH_OFFSET) begin
				verdict.status = ST_LEN_MISMATCH;
			end else if (frame_sum != item.data_byte) begin
				verdict.status = ST_SUM_MISMATCH;
			end else begin
				verdict.status = ST_VALID;
			end
			verdict.sender_high     = sender_hi_seen;
			verdict.sender_low      = sender_lo_seen;
			verdict.declared_length = length_seen;
			expected_verdicts.push_back(verdict);
			clear_frame_state();
		end
	endtask

	// Four-state compare, so an unknown output bit counts as a mismatch
	task automatic check_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			fails++;
		end
	endtask

	// Verdicts are compared before bytes are folded in the same cycle
	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t oldest;
		if (!arst_n) begin
			hdr_first_now  = HEADER_FIRST_RST;
			hdr_second_now = HEADER_SECOND_RST;
			clear_frame_state();
			expected_verdicts.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: verdict with no frame outstanding, actual status %0d",
						$time, out_data.status);
					fails++;
				end else begin
					oldest = expected_verdicts.pop_front();
					check_field("status", 8'(oldest.status), 8'(out_data.status));
					check_field("sender_high", oldest.sender_high, out_data.sender_high);
					check_field("sender_low", oldest.sender_low, out_data.sender_low);
					check_field("declared_length", oldest.declared_length,
						out_data.declared_length);
					checked++;
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_HEADER_FIRST) hdr_first_now = cfg_wdata;
				else hdr_second_now = cfg_wdata;
			end
			if (in_valid && in_ready) fold_frame_byte(in_data);
		end
		mismatch_count   <= fails;
		verdicts_pending <= expected_verdicts.size();
		verdicts_checked <= checked;
	end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the frame header, length and checksum checker.
// Sends a few hand-built frames, then random frames under several header
// settings: mostly well-formed ones with random content, plus short, corrupt,
// noise and one overlong frame. Both sides idle at random; the verdict side
// holds off once for a long stretch. A separate checker does the comparing.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fhlc_pkg::*;

	localparam int NUM_PHASES       = 5;
	localparam int PHASE_BYTES      = 50;
	localparam int MIN_PHASE_FRAMES = 4;
	localparam int OVERLONG_LEN     = 512;
	localparam int SETTLE_CYCLES    = 4;
	localparam int TAIL_CYCLES      = 8;
	localparam int LONG_HOLD_AFTER  = 6;
	localparam int LONG_HOLD_CYCLES = 600;
	localparam int WATCHDOG_LIMIT   = 3000;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_item_t   in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;
	logic       cfg_we    = 1'b0;
	logic [0:0] cfg_index = REG_HEADER_FIRST;
	logic [7:0] cfg_wdata = '0;

	int mismatch_count;
	int verdicts_pending;
	int verdicts_checked;

	// Header values the block currently expects, for building good frames
	logic [7:0] hdr_a = HEADER_FIRST_RST;
	logic [7:0] hdr_b = HEADER_SECOND_RST;
	logic [7:0] frame_q[$];
	int bytes_sent      = 0;
	int frames_sent     = 0;
	int send_burst_left = 0;
	int idle_cycles     = 0;

	always #5 clk = ~clk;

	frame_header_length_checksum_check_unit DUT (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data,
		.cfg_we,
		.cfg_index,
		.cfg_wdata
	);

	fhlc_verdict_checker verdict_checker (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data,
		.cfg_we,
		.cfg_index,
		.cfg_wdata,
		.mismatch_count,
		.verdicts_pending,
		.verdicts_checked
	);

	// One byte transaction; valid stays high afterward until the next call or a pause
	task automatic send_byte(input logic [7:0] value, input logic is_last);
		int gap;
		if (send_burst_left > 0) begin
			gap = 0;
			send_burst_left--;
		end else begin
			gap = $urandom_range(0, 19);
			if ($urandom_range(0, 31) == 0) send_burst_left = $urandom_range(8, 40);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{data_byte: value, last_byte: is_last};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_queued_frame();
		int i;
		for (i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
		frames_sent++;
	endtask

	// Close the queued frame with its checksum, plus an offset to spoil it
	task automatic push_checksum(input logic [7:0] offset);
		logic [7:0] acc;
		int i;
		acc = offset;
		for (i = 0; i < frame_q.size(); i++) acc = acc + frame_q[i];
		frame_q.push_back(acc);
	endtask

	task automatic send_random_frame(input int frame_len, input bit force_good);
		int kind, i;
		logic [1:0] hdr_err;
		logic [7:0] b;
		bit bad_len, bad_sum, noise;
		hdr_err = 2'b00;
		bad_len = 1'b0;
		bad_sum = 1'b0;
		noise   = 1'b0;
		if (!force_good) begin
			kind = $urandom_range(0, 99);
			if (kind >= 94) noise = 1'b1;
			else if (kind >= 86) bad_sum = 1'b1;
			else if (kind >= 78) bad_len = 1'b1;
			else if (kind >= 70) hdr_err = 2'($urandom_range(1, 3));
		end
		frame_q.delete();
		for (i = 0; i < frame_len - 1; i++) begin
			b = 8'($urandom);
			if (!noise) begin
				case (i)
					0: b = hdr_a ^ (hdr_err[0] ? 8'($urandom_range(1, 255)) : 8'd0);
					1: b = hdr_b ^ (hdr_err[1] ? 8'($urandom_range(1, 255)) : 8'd0);
					2: b = 8'(frame_len - LENGTH_OFFSET)
						^ (bad_len ? 8'($urandom_range(1, 255)) : 8'd0);
					default: ;
				endcase
			end
			frame_q.push_back(b);
		end
		if (noise) frame_q.push_back(8'($urandom));
		else push_checksum(bad_sum ? 8'($urandom_range(1, 255)) : 8'd0);
		send_queued_frame();
	endtask

	// Stop offering bytes and wait until every verdict has been taken
	task automatic drain_verdicts();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_pending != 0) @(posedge clk);
	endtask

	task automatic write_headers(input logic [7:0] first, input logic [7:0] second);
		cfg_we    <= 1'b1;
		cfg_index <= REG_HEADER_FIRST;
		cfg_wdata <= first;
		@(posedge clk);
		cfg_index <= REG_HEADER_SECOND;
		cfg_wdata <= second;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		hdr_a = first;
		hdr_b = second;
	endtask

	// Byte source and final verdict
	initial begin : stimulus
		int phase, frames_in_phase, directed_bytes, frame_len, sel;
		logic [7:0] new_first, new_second;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-built frames under the reset header values
		frame_q = '{8'h00};                       // lone final byte
		send_queued_frame();
		frame_q = '{hdr_a, hdr_b, 8'h07, 8'hFF};  // too short, sender_low never reached
		send_queued_frame();
		frame_q = '{hdr_a, hdr_b, 8'h02, 8'hFF};  // shortest valid frame
		push_checksum(8'h00);
		send_queued_frame();
		frame_q = '{hdr_a, 8'h00, 8'h02, 8'h01};  // second header byte wrong
		push_checksum(8'h00);
		send_queued_frame();
		frame_q = '{hdr_a, hdr_b, 8'hFF, 8'h00};  // declared length wrong
		push_checksum(8'h00);
		send_queued_frame();
		frame_q = '{hdr_a, hdr_b, 8'h03, 8'hFF, 8'hFF};  // checksum off by one
		push_checksum(8'h01);
		send_queued_frame();
		directed_bytes = bytes_sent;

		// Random frames, one header setting per phase
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase > 0) begin
				drain_verdicts();
				repeat (SETTLE_CYCLES) @(posedge clk);
				case (phase)
					1: begin
						new_first  = 8'h00;
						new_second = 8'hFF;
					end
					2: begin
						new_first  = 8'hFF;
						new_second = 8'h00;
					end
					3: begin
						new_first  = 8'($urandom);
						new_second = 8'($urandom);
					end
					default: begin
						new_first  = HEADER_FIRST_RST;
						new_second = HEADER_SECOND_RST;
					end
				endcase
				write_headers(new_first, new_second);
			end
			frames_in_phase = 0;
			while (bytes_sent < directed_bytes + (phase + 1) * PHASE_BYTES ||
					frames_in_phase < MIN_PHASE_FRAMES) begin
				if (phase == 2 && frames_in_phase == 1) begin
					// byte count saturates, so the length check must fail
					send_random_frame(OVERLONG_LEN, 1'b1);
				end else begin
					sel = $urandom_range(0, 99);
					if (sel < 8) frame_len = $urandom_range(1, 4);
					else if (sel < 85) frame_len = $urandom_range(5, 14);
					else frame_len = $urandom_range(15, 40);
					send_random_frame(frame_len, 1'b0);
				end
				frames_in_phase++;
				if (phase == 1 && frames_in_phase == 6) drain_verdicts();
			end
		end

		drain_verdicts();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d bytes in %0d frames under %0d header settings; %0d verdicts checked.",
			bytes_sent, frames_sent, NUM_PHASES, verdicts_checked);
		$display("Frames ran from a lone final byte to %0d bytes; verdict side stalled %0d cycles.",
			OVERLONG_LEN, LONG_HOLD_CYCLES);
		if (mismatch_count == 0 && verdicts_pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Verdict sink: random waits, bursts, and one long hold-off
	initial begin : verdict_sink
		int gap, taken, burst_left;
		taken      = 0;
		burst_left = 0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken == LONG_HOLD_AFTER) begin
				gap = LONG_HOLD_CYCLES;
			end else if (burst_left > 0) begin
				gap = 0;
				burst_left--;
			end else begin
				gap = $urandom_range(0, 19);
				if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(4, 12);
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
hw/rtl/fhlc_pkg.sv
hw/rtl/fhlc_frame_check.sv
hw/rtl/fhlc_out_reg.sv
hw/rtl/frame_header_length_checksum_check_unit.sv
dv/fhlc_verdict_checker.sv
dv/testbench.sv
